[design/seia_pkg.sv]
// Shared types and constants for the squared effort impulse accumulator.
package seia_pkg;
  localparam int unsigned TimeW = 48;
  localparam int unsigned IdxW = 5;
  localparam int unsigned EffW = 32;
  localparam int unsigned SumW = 64;
  localparam int unsigned MagW = 33;
  localparam int unsigned ProdW = 81;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef struct packed {
    logic start;
    logic [1:0] op;
  } seia_cmd_t;

  typedef struct packed {
    logic busy;
  } seia_stat_t;

  localparam logic [1:0] OpNone = 2'd0;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? SumMax : s[SumW-1:0];
  endfunction
endpackage

[design/seia_if.sv]
// Valid/ready channel interfaces for input and result words.
interface seia_in_if;
  logic valid;
  logic ready;
  logic [seia_pkg::TimeW-1:0] time_stamp;
  logic [seia_pkg::IdxW-1:0] joint_index;
  logic signed [seia_pkg::EffW-1:0] effort;
  logic last_joint;
  modport source (output valid, time_stamp, joint_index, effort, last_joint, input ready);
  modport sink (input valid, time_stamp, joint_index, effort, last_joint, output ready);
endinterface

interface seia_out_if;
  logic valid;
  logic ready;
  logic [seia_pkg::SumW-1:0] message_delta;
  logic [seia_pkg::SumW-1:0] running_total;
  logic baseline_only;
  modport source (output valid, message_delta, running_total, baseline_only, input ready);
  modport sink (input valid, message_delta, running_total, baseline_only, output ready);
endinterface

[design/seia_datapath.sv]
// Datapath: serial multiplier, serial divider and squaring for one joint sample.
module seia_datapath (
  input  logic clk,
  input  logic rst_n,
  input  seia_pkg::seia_cmd_t cmd,
  input  logic [seia_pkg::TimeW-1:0] dt,
  input  logic signed [seia_pkg::EffW-1:0] e_in,
  input  logic signed [seia_pkg::EffW-1:0] l_in,
  output seia_pkg::seia_stat_t stat,
  output logic [seia_pkg::SumW-1:0] add_out
);
  localparam int unsigned MW = seia_pkg::MagW;
  localparam int unsigned PW = seia_pkg::ProdW;
  localparam int unsigned CntW = 7;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_L1, S_SQ, S_NEXT, S_DONE
  } dstate_t;

  dstate_t state_r;
  logic [CntW-1:0] cnt_r;
  logic split_r;
  logic [1:0] phase_r;
  logic [MW-1:0] me_r, ml_r;
  logic [seia_pkg::TimeW-1:0] dt_r;
  logic [PW-1:0] acc_r;
  logic [PW-1:0] mcand_r;
  logic [seia_pkg::TimeW+1:0] mplier_r;
  logic [MW+1:0] rem_r;
  logic [seia_pkg::TimeW-1:0] l1_r;
  logic [seia_pkg::SumW-1:0] add_r;
  logic [seia_pkg::SumW-1:0] first_r;
  logic [97:0] sq_r;

  logic signed [MW:0] e_x, l_x, sum_x;
  logic [MW-1:0] me_w, ml_w, ms_w;
  logic [MW:0] div_d;
  logic [MW+1:0] rem_sh;
  logic [seia_pkg::SumW-1:0] sq_val;
  logic [24:0] sq_a, sq_b;
  logic [49:0] sq_pp;
  logic [97:0] sq_sh;

  always_comb begin
    e_x = {{2{e_in[seia_pkg::EffW-1]}}, e_in};
    l_x = {{2{l_in[seia_pkg::EffW-1]}}, l_in};
    sum_x = e_x + l_x;
    me_w = e_in[seia_pkg::EffW-1] ? MW'(-e_x) : MW'(e_x);
    ml_w = l_in[seia_pkg::EffW-1] ? MW'(-l_x) : MW'(l_x);
    ms_w = sum_x[MW] ? MW'(-sum_x) : MW'(sum_x);
    div_d = {1'b0, me_r} + {1'b0, ml_r};
    rem_sh = {rem_r[MW:0], acc_r[PW-1]};
    // The 49-bit product is squared as three partial products of its 25-bit halves.
    sq_a = (cnt_r == CntW'(0)) ? acc_r[24:0] : {1'b0, acc_r[48:25]};
    sq_b = (cnt_r == CntW'(2)) ? {1'b0, acc_r[48:25]} : acc_r[24:0];
    sq_pp = {25'b0, sq_a} * {25'b0, sq_b};
    if (cnt_r == CntW'(0)) sq_sh = {48'b0, sq_pp};
    else if (cnt_r == CntW'(1)) sq_sh = {22'b0, sq_pp, 26'b0};
    else sq_sh = {sq_pp[47:0], 50'b0};
    if (acc_r[PW-1:49] != '0) sq_val = seia_pkg::SumMax;
    else sq_val = sq_r[97:34];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            me_r <= me_w;
            ml_r <= ml_w;
            dt_r <= dt;
            split_r <= (e_in != '0) && (l_in != '0) &&
                       (e_in[seia_pkg::EffW-1] != l_in[seia_pkg::EffW-1]);
            acc_r <= '0;
            mcand_r <= PW'(((e_in != '0) && (l_in != '0) &&
                       (e_in[seia_pkg::EffW-1] != l_in[seia_pkg::EffW-1])) ? me_w : ms_w);
            mplier_r <= {2'b0, dt};
            phase_r <= 2'd0;
            cnt_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          if (cnt_r == CntW'(seia_pkg::TimeW + 1)) begin
            cnt_r <= '0;
            rem_r <= '0;
            sq_r <= '0;
            if (split_r && phase_r == 2'd0) state_r <= S_DIV;
            else state_r <= S_SQ;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          // Restoring division of dt*|e| by |e|+|l|, one quotient bit per cycle.
          if (rem_sh >= {1'b0, div_d}) begin
            rem_r <= rem_sh - {1'b0, div_d};
            acc_r <= {acc_r[PW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            acc_r <= {acc_r[PW-2:0], 1'b0};
          end
          if (cnt_r == CntW'(PW - 1)) begin
            cnt_r <= '0;
            state_r <= S_L1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_L1: begin
          // Quotient is below dt, so its low bits hold l1 exactly.
          l1_r <= acc_r[seia_pkg::TimeW-1:0];
          acc_r <= '0;
          mcand_r <= PW'(me_r);
          mplier_r <= {2'b0, acc_r[seia_pkg::TimeW-1:0]};
          phase_r <= 2'd1;
          state_r <= S_MUL;
        end
        S_SQ: begin
          sq_r <= sq_r + sq_sh;
          if (cnt_r == CntW'(2)) begin
            cnt_r <= '0;
            state_r <= S_NEXT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_NEXT: begin
          case (phase_r)
            2'd1: begin
              first_r <= sq_val;
              acc_r <= '0;
              mcand_r <= PW'(ml_r);
              mplier_r <= {2'b0, dt_r - l1_r};
              phase_r <= 2'd2;
              state_r <= S_MUL;
            end
            2'd2: begin
              add_r <= seia_pkg::sat_add(first_r, sq_val);
              state_r <= S_DONE;
            end
            default: begin
              add_r <= sq_val;
              state_r <= S_DONE;
            end
          endcase
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != S_IDLE) || (cmd.op != seia_pkg::OpNone);
  assign add_out = add_r;
endmodule

[design/seia_ctrl.sv]
// Controller: input handshake, joint store, per-message sums and result register.
module seia_ctrl #(
  parameter int unsigned MAX_JOINTS = 32
) (
  input  logic clk,
  input  logic rst_n,
  seia_in_if.sink in_ch,
  seia_out_if.source out_ch,
  output seia_pkg::seia_cmd_t cmd,
  input  seia_pkg::seia_stat_t stat,
  output logic [seia_pkg::TimeW-1:0] dt,
  output logic signed [seia_pkg::EffW-1:0] e_out,
  output logic signed [seia_pkg::EffW-1:0] l_out,
  input  logic [seia_pkg::SumW-1:0] add_in
);
  localparam int unsigned AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  typedef enum logic [2:0] {C_IDLE, C_READ, C_START, C_WAIT, C_FIN} cstate_t;

  cstate_t state_r;
  logic [seia_pkg::EffW-1:0] mem [MAX_JOINTS];
  logic [seia_pkg::EffW-1:0] rd_r;
  logic [seia_pkg::TimeW-1:0] prev_time_r, now_r;
  logic [seia_pkg::EffW-1:0] eff_r;
  logic [AW-1:0] idx_r;
  logic in_range_r, last_r, base_r;
  logic [seia_pkg::SumW-1:0] delta_r, total_r;
  logic out_valid_r;
  logic [seia_pkg::SumW-1:0] o_delta_r, o_total_r;
  logic o_base_r;
  logic in_range_w;
  logic fin_emit;

  assign in_range_w = {4'b0, in_ch.joint_index} < 9'(MAX_JOINTS);
  assign in_ch.ready = (state_r == C_IDLE);
  // A message end waits only while the previous result word is still held.
  assign fin_emit = (state_r == C_FIN) && last_r && (!out_valid_r || out_ch.ready);
  assign dt = (now_r >= prev_time_r) ? now_r - prev_time_r : prev_time_r - now_r;
  assign e_out = eff_r;
  assign l_out = rd_r;
  assign cmd.start = (state_r == C_START);
  assign cmd.op = seia_pkg::OpNone;
  assign out_ch.valid = out_valid_r;
  assign out_ch.message_delta = o_delta_r;
  assign out_ch.running_total = o_total_r;
  assign out_ch.baseline_only = o_base_r;

  always_ff @(posedge clk) begin
    rd_r <= mem[idx_r];
    if (state_r == C_FIN && in_range_r) mem[idx_r] <= eff_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      prev_time_r <= '0;
      base_r <= 1'b0;
      delta_r <= '0;
      total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_emit) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            now_r <= in_ch.time_stamp;
            eff_r <= in_ch.effort;
            idx_r <= AW'(in_ch.joint_index);
            in_range_r <= in_range_w;
            last_r <= in_ch.last_joint;
            state_r <= (in_range_w && base_r) ? C_READ : C_FIN;
          end
        end
        C_READ: state_r <= C_START;
        C_START: state_r <= C_WAIT;
        C_WAIT: begin
          if (!stat.busy) begin
            delta_r <= seia_pkg::sat_add(delta_r, add_in);
            state_r <= C_FIN;
          end
        end
        C_FIN: begin
          if (!last_r) begin
            state_r <= C_IDLE;
          end else if (fin_emit) begin
            state_r <= C_IDLE;
            prev_time_r <= now_r;
            delta_r <= '0;
            if (!base_r) begin
              base_r <= 1'b1;
              o_delta_r <= '0;
              o_total_r <= total_r;
              o_base_r <= 1'b1;
            end else begin
              total_r <= seia_pkg::sat_add(total_r, delta_r);
              o_delta_r <= delta_r;
              o_total_r <= seia_pkg::sat_add(total_r, delta_r);
              o_base_r <= 1'b0;
            end
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end
endmodule

[design/squared_effort_impulse_accumulator.sv]
// A word that adds work runs a 50-step serial multiply and a 3-step split square; a
// sign-flip word runs three multiplies, an 81-step divide and two squares. One word is
// in flight at a time. Baseline words and out-of-range joints bypass the datapath. A
// result waits in an output register; a message end stalls only while the previous
// result is still held.
// Synchronous active-low reset clears sums, baseline flag, previous time and result valid.
module squared_effort_impulse_accumulator #(
  parameter int unsigned MAX_JOINTS = 32
) (
  input  logic clk,
  input  logic rst_n,
  seia_in_if.sink in_ch,
  seia_out_if.source out_ch
);
  seia_pkg::seia_cmd_t cmd;
  seia_pkg::seia_stat_t stat;
  logic [seia_pkg::TimeW-1:0] dt;
  logic signed [seia_pkg::EffW-1:0] e_w, l_w;
  logic [seia_pkg::SumW-1:0] add_w;

  seia_ctrl #(.MAX_JOINTS(MAX_JOINTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cmd(cmd),
    .stat(stat), .dt(dt), .e_out(e_w), .l_out(l_w), .add_in(add_w)
  );

  seia_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .dt(dt), .e_in(e_w), .l_in(l_w),
    .stat(stat), .add_out(add_w)
  );

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !(in_ch.valid && in_ch.ready)) else $error("accept while busy");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.message_delta) &&
    $stable(out_ch.running_total)) else $error("result changed while waiting");
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> stat.busy) else $error("start lost");
endmodule

[sim/seia_checker.sv]
// Result checker: predicts each result word from accepted input words and compares.
`timescale 1ns / 1ps
module seia_checker (
  input  logic clk,
  input  logic rst_n,
  seia_in_if   in_ch,
  seia_out_if  out_ch,
  output int   errors,
  output int   pending
);
  typedef struct {
    logic [seia_pkg::SumW-1:0] delta;
    logic [seia_pkg::SumW-1:0] total;
    logic                      baseline;
  } impulse_result_t;

  impulse_result_t owed_results[$];

  logic [seia_pkg::EffW-1:0]  last_effort [32];
  logic [seia_pkg::TimeW-1:0] last_time;
  logic                       have_baseline;
  logic [seia_pkg::SumW-1:0]  delta_acc;
  logic [seia_pkg::SumW-1:0]  total_acc;

  function automatic logic [seia_pkg::SumW-1:0] clip_add(logic [seia_pkg::SumW-1:0] a,
                                                         logic [seia_pkg::SumW-1:0] b);
    logic [seia_pkg::SumW:0] s;
    s = a + b;
    if (s > {1'b0, seia_pkg::SumMax}) return seia_pkg::SumMax;
    return s[seia_pkg::SumW-1:0];
  endfunction

  // Square of half the product a*b in Q32.32; saturates once the product reaches 2^49.
  function automatic logic [seia_pkg::SumW-1:0] half_area_sq(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [127:0] q;
    p = 128'(a) * 128'(b);
    if (p >= (128'd1 << 49)) return seia_pkg::SumMax;
    q = p * p;
    return q[97:34];
  endfunction

  function automatic logic [seia_pkg::SumW-1:0] joint_impulse(
      logic [seia_pkg::TimeW-1:0] now,
      logic [seia_pkg::EffW-1:0] eff,
      logic [seia_pkg::EffW-1:0] prev,
      logic [seia_pkg::TimeW-1:0] then_t);
    logic [63:0]  dt;
    longint       e;
    longint       l;
    longint       s;
    logic [63:0]  me;
    logic [63:0]  ml;
    logic [127:0] split;
    logic [63:0]  l1;
    dt = (now >= then_t) ? 64'(now - then_t) : 64'(then_t - now);
    e = longint'(signed'(eff));
    l = longint'(signed'(prev));
    if (e != 0 && l != 0 && ((e < 0) != (l < 0))) begin
      me = (e < 0) ? -e : e;
      ml = (l < 0) ? -l : l;
      // The step is cut at the zero crossing of the straight line between samples.
      split = (128'(dt) * 128'(me)) / 128'(me + ml);
      l1 = split[63:0];
      return clip_add(half_area_sq(me, l1), half_area_sq(ml, dt - l1));
    end
    s = e + l;
    return half_area_sq(dt, (s < 0) ? -s : s);
  endfunction

  task automatic impulse_predict(logic [seia_pkg::TimeW-1:0] now,
                                 logic [seia_pkg::IdxW-1:0] idx,
                                 logic [seia_pkg::EffW-1:0] eff, logic last);
    impulse_result_t r;
    if (have_baseline)
      delta_acc = clip_add(delta_acc, joint_impulse(now, eff, last_effort[idx], last_time));
    last_effort[idx] = eff;
    if (last) begin
      if (!have_baseline) begin
        have_baseline = 1'b1;
        r.delta = '0;
        r.baseline = 1'b1;
      end else begin
        total_acc = clip_add(total_acc, delta_acc);
        r.delta = delta_acc;
        r.baseline = 1'b0;
      end
      r.total = total_acc;
      owed_results.push_back(r);
      delta_acc = '0;
      last_time = now;
    end
  endtask

  task automatic note_mismatch(string what, logic [seia_pkg::SumW-1:0] want,
                               logic [seia_pkg::SumW-1:0] got);
    if (errors < 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    errors++;
  endtask

  assign pending = owed_results.size();

  initial errors = 0;

  always @(posedge clk) begin
    impulse_result_t exp_r;
    if (!rst_n) begin
      have_baseline = 1'b0;
      last_time = '0;
      delta_acc = '0;
      total_acc = '0;
      owed_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          if (errors < 10) $display("%0t: result word with none expected", $time);
          errors++;
        end else begin
          exp_r = owed_results.pop_front();
          if (out_ch.message_delta !== exp_r.delta)
            note_mismatch("message_delta", exp_r.delta, out_ch.message_delta);
          if (out_ch.running_total !== exp_r.total)
            note_mismatch("running_total", exp_r.total, out_ch.running_total);
          if (out_ch.baseline_only !== exp_r.baseline)
            note_mismatch("baseline_only", 64'(exp_r.baseline), 64'(out_ch.baseline_only));
        end
      end
      if (in_ch.valid && in_ch.ready)
        impulse_predict(in_ch.time_stamp, in_ch.joint_index, in_ch.effort, in_ch.last_joint);
    end
  end
endmodule

[sim/tb_squared_effort_impulse_accumulator.sv]
// Testbench top: drives effort words, applies back-pressure and reports the verdict.
`timescale 1ns / 1ps
module tb_squared_effort_impulse_accumulator;
  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   hold_left;
  bit   calm;
  logic [seia_pkg::TimeW-1:0] msg_time;

  seia_in_if  in_ch ();
  seia_out_if out_ch ();

  squared_effort_impulse_accumulator i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  seia_checker i_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .errors (errors),
    .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic send_word(logic [seia_pkg::TimeW-1:0] ts, logic [seia_pkg::IdxW-1:0] idx,
                           logic [seia_pkg::EffW-1:0] eff, logic last);
    bit taken;
    if (!calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.time_stamp <= ts;
    in_ch.joint_index <= idx;
    in_ch.effort <= eff;
    in_ch.last_joint <= last;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic [seia_pkg::EffW-1:0] pick_effort();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3, 4: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh8_0000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    int lo;
    logic [seia_pkg::TimeW-1:0] ts;
    hold_left = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.time_stamp = '0;
    in_ch.joint_index = '0;
    in_ch.effort = '0;
    in_ch.last_joint = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Samples with no last flag before the baseline: stored, no result.
    send_word(48'd5, 5'd0, 32'h0001_0000, 1'b0);
    send_word(48'd5, 5'd1, 32'hffff_0000, 1'b0);
    // Baseline message covers every joint, with the effort extremes among them.
    for (int j = 0; j < 32; j++)
      send_word(48'd0, j[4:0], (j == 0) ? 32'h7fff_ffff : (j == 1) ? 32'h8000_0000 :
                (j == 2) ? 32'h0 : (j == 3) ? 32'hffff_ffff : $urandom, j == 31);
    // Sign flips at the extremes, zero against nonzero, same sign.
    send_word(48'h1_0000, 5'd0, 32'h8000_0000, 1'b0);
    send_word(48'h1_0000, 5'd1, 32'h7fff_ffff, 1'b0);
    send_word(48'h1_0000, 5'd2, 32'h0001_0000, 1'b0);
    send_word(48'h1_0000, 5'd3, 32'hffff_ffff, 1'b1);
    // Largest time step saturates, then time runs backwards.
    send_word(48'hffff_ffff_ffff, 5'd4, 32'h0000_1000, 1'b1);
    send_word(48'h2_0000, 5'd0, 32'h7fff_ffff, 1'b0);
    send_word(48'h2_0000, 5'd31, 32'h0, 1'b1);
    // Mixed times inside one message.
    send_word(48'h3_0000, 5'd5, 32'h0002_0000, 1'b0);
    send_word(48'h3_8000, 5'd6, 32'hfffe_0000, 1'b0);
    send_word(48'h2_8000, 5'd7, 32'h0, 1'b1);

    msg_time = 48'h3_0000;
    for (int m = 0; m < 110; m++) begin
      if (m == 5) hold_left = 400;
      calm = (m >= 40 && m < 60);
      case ($urandom_range(19))
        0: msg_time = msg_time + 48'($urandom) + (48'($urandom) << 16);
        1: msg_time = msg_time - 48'($urandom_range(0, 20'hfffff));
        2: msg_time = 48'($urandom) | (48'($urandom) << 32);
        default: msg_time = msg_time + 48'($urandom_range(0, 20'hfffff));
      endcase
      n = $urandom_range(1, 6);
      lo = $urandom_range(0, 31);
      for (int k = 0; k < n; k++) begin
        ts = ($urandom_range(9) == 0) ? msg_time + 48'($urandom_range(0, 16'hffff)) : msg_time;
        // Mostly ascending joints; now and then a word with its last flag dropped.
        send_word(ts, ($urandom_range(7) == 0) ? 5'($urandom) : 5'(lo + k), pick_effort(),
                  (k == n - 1) && ($urandom_range(15) != 0));
      end
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    n = 0;
    while (pending != 0 && n < 100_000) begin
      @(posedge clk);
      n++;
    end
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
